// ===== design/crcf_pkg.sv =====
`default_nettype none

package crcf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam int BLOCK_BYTES = 16;
   localparam int SEED_BYTES = 4;
   localparam int VEC_BITS = 8 * (BLOCK_BYTES + SEED_BYTES);
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [VEC_BITS-1:0] data_vec;
      logic [4:0]          byte_count;
      logic                first;
      logic                last;
      logic [31:0]         seed;
   } crcf_entry_type;

   typedef logic [VEC_BITS-1:0][31:0] fwd_tbl_type;
   typedef logic [31:0][31:0] inv_tbl_type;

   // one bit of the reflected crc shift
   function automatic logic [31:0] crc_step(input logic [31:0] r);
      return (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
   endfunction

   // undoes crc_step, the polynomial has its top bit set
   function automatic logic [31:0] crc_unstep(input logic [31:0] r);
      logic [31:0] x;
      x = r[31] ? (r ^ CRC_POLY) : r;
      return {x[30:0], r[31]};
   endfunction

   // crc of a single set bit at each place of the vector
   function automatic fwd_tbl_type build_fwd_table();
      fwd_tbl_type tbl;
      logic [31:0] r;
      r = 32'h1;
      for (int j = VEC_BITS - 1; j >= 0; j--) begin
         r = crc_step(r);
         tbl[j] = r;
      end
      return tbl;
   endfunction

   // block that gives each register bit after four bytes from zero
   function automatic inv_tbl_type build_inv_table();
      inv_tbl_type tbl;
      logic [31:0] r;
      for (int c = 0; c < 32; c++) begin
         r = 32'h1 << c;
         for (int k = 0; k < 32; k++) begin
            r = crc_unstep(r);
         end
         tbl[c] = r;
      end
      return tbl;
   endfunction

   localparam fwd_tbl_type FWD_TABLE = build_fwd_table();
   localparam inv_tbl_type INV_TABLE = build_inv_table();

endpackage

`default_nettype wire

// ===== design/crcf_front.sv =====
`default_nettype none

module crcf_front import crcf_pkg::*; (
   input  wire logic [63:0]    req_data_low,
   input  wire logic [63:0]    req_data_high,
   input  wire logic [4:0]     req_byte_count,
   input  wire logic           req_first,
   input  wire logic           req_last,
   input  wire logic [31:0]    req_seed,
   output crcf_entry_type      entry
);

   logic [4:0] count_sat;
   logic [4:0] count_eff;
   logic [7:0] data_shift;

   always_comb begin
      count_sat = (req_byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : req_byte_count;
      count_eff = req_last ? count_sat : 5'(BLOCK_BYTES);
      // data ends at the top of the vector, bytes beyond the count fall off
      data_shift = (8'(BLOCK_BYTES + SEED_BYTES) - {3'b000, count_eff}) << 3;
      entry.data_vec   = VEC_BITS'({req_data_high, req_data_low}) << data_shift;
      entry.byte_count = count_eff;
      entry.first      = req_first;
      entry.last       = req_last;
      entry.seed       = req_seed;
   end

endmodule

`default_nettype wire

// ===== design/crcf_queue.sv =====
`default_nettype none

module crcf_queue import crcf_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  crcf_entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output crcf_entry_type head_entry
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   crcf_entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      full       = (count_ff == CntW'(Depth));
      head_valid = (count_ff != '0);
      head_entry = entries_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/crcf_back.sv =====
`default_nettype none

module crcf_back import crcf_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  crcf_entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic [31:0]    rsp_crc_value
);

   logic [31:0] crc_state_ff, crc_state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;
   logic [31:0] start_reg;
   logic [31:0] seed_block;
   logic [7:0]  seed_shift;
   logic [VEC_BITS-1:0] fold_vec;
   logic [31:0] crc_next;

   always_comb begin
      pop = head_valid && (!head_entry.last || !rsp_valid_ff || !rsp_stall);
      start_reg = head_entry.first ? ~head_entry.seed : crc_state_ff;
      // four bytes that bring a zero register to start_reg
      seed_block = '0;
      for (int c = 0; c < 32; c++) begin
         if (start_reg[c]) begin
            seed_block = seed_block ^ INV_TABLE[c];
         end
      end
      seed_shift = (8'(BLOCK_BYTES) - {3'b000, head_entry.byte_count}) << 3;
      fold_vec = (VEC_BITS'(seed_block) << seed_shift) ^ head_entry.data_vec;
      crc_next = '0;
      for (int j = 0; j < VEC_BITS; j++) begin
         if (fold_vec[j]) begin
            crc_next = crc_next ^ FWD_TABLE[j];
         end
      end
      crc_state_in = crc_state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_crc_in   = rsp_crc_ff;
      if (pop) begin
         if (head_entry.last) begin
            crc_state_in = '0;
            rsp_valid_in = 1'b1;
            rsp_crc_in   = ~crc_next;
         end else begin
            crc_state_in = crc_next;
         end
      end
      rsp_valid     = rsp_valid_ff;
      rsp_crc_value = rsp_crc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_state_ff <= crc_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

`ifndef SYNTH
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.last) |=> (crc_state_ff == '0))
      else $error("crc state not cleared after last word");
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && head_entry.last))
      else $error("response without last word");
`endif

endmodule

`default_nettype wire

// ===== design/crc32_clmul_fold_core.sv =====
`default_nettype none

// reflected crc-32 (poly 0xedb88320, inverted seed and result) over 16-byte words
// req channel: one word per accepted beat, data_low holds bytes 0..7, data_high 8..15;
//   first loads seed, last closes the message and may carry 0 to 16 bytes
// rsp channel: one crc_value per last word, in order, none for other words
// a queued word reaches the back end after the words ahead of it; the crc of a last
//   word is registered there, so rsp_valid rises the cycle after that word is popped
// throughput: one word per cycle while rsp is not stalled, set by the back end's
//   combinational 32-bit crc state update (seed-to-block matrix, 160-bit xor matrix)
// a small queue sits between the front end and the back end; non-last words keep
//   draining while rsp is stalled, a last word waits in the queue for the output
//   register, and req_stall rises once the queue is full
// reset clears the queue, the crc state and rsp_valid; no clearing pass is needed
// an item without first while no message is open starts from an all-ones seed
module crc32_clmul_fold_core import crcf_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_low,
   input  wire logic [63:0] req_data_high,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic        req_first,
   input  wire logic        req_last,
   input  wire logic [31:0] req_seed,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_crc_value
);

   crcf_entry_type front_entry;
   crcf_entry_type head_entry;
   logic           queue_full;
   logic           head_valid;
   logic           head_pop;
   logic           push;

   assign push      = req_valid && !queue_full;
   assign req_stall = queue_full;

   crcf_front u_front (
      .req_data_low   (req_data_low),
      .req_data_high  (req_data_high),
      .req_byte_count (req_byte_count),
      .req_first      (req_first),
      .req_last       (req_last),
      .req_seed       (req_seed),
      .entry          (front_entry)
   );

   crcf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   crcf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (head_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

`default_nettype wire

// ===== tb/sv/crc32_clmul_fold_core_test.sv =====
`default_nettype none

module crc32_clmul_fold_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
   localparam int RANDOM_WORDS = 1250;
   localparam int DIR_ROWS = 20;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  count;
      logic        first;
      logic        last;
      logic [31:0] seed;
      logic        known;
      logic [31:0] crc;
   } word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_low = '0;
   logic [63:0] req_data_high = '0;
   logic [4:0]  req_byte_count = '0;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic [31:0] req_seed = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_crc_value;

   crc32_clmul_fold_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_low(req_data_low),
      .req_data_high(req_data_high),
      .req_byte_count(req_byte_count),
      .req_first(req_first),
      .req_last(req_last),
      .req_seed(req_seed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_crc_value(rsp_crc_value)
   );

   word_type    dir_tab [DIR_ROWS];
   word_type    feed_q [$];
   logic [31:0] crc_q [$];
   int          total_words = 0;
   int          words_taken = 0;
   int          idle_cycles = 0;
   int          errors = 0;

   // predictor state: pending block and open-message flag
   logic [127:0] acc_blk = '0;
   bit           msg_open = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] crc_shift_byte(logic [31:0] r, logic [7:0] b);
      r = r ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ REFLECTED_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] crc_run(logic [31:0] r, logic [127:0] blk, int n);
      for (int i = 0; i < n; i++) begin
         r = crc_shift_byte(r, blk[8*i +: 8]);
      end
      return r;
   endfunction

   task automatic predict_word(input word_type w, output bit has_crc, output logic [31:0] crc);
      logic [31:0] r;
      int          n;
      if (w.first) begin
         r = ~w.seed;
      end else if (msg_open) begin
         r = crc_run(32'h0, acc_blk, 16);
      end else begin
         r = 32'h0;
      end
      if (!w.last) begin
         acc_blk = {w.hi, w.lo ^ {32'h0, r}};
         msg_open = 1'b1;
         has_crc = 1'b0;
         crc = 32'h0;
      end else begin
         n = (w.count > 5'd16) ? 16 : int'(w.count);
         crc = ~crc_run(r, {w.hi, w.lo}, n);
         has_crc = 1'b1;
         acc_blk = '0;
         msg_open = 1'b0;
      end
   endtask

   function automatic word_type rand_word(logic first, logic last, logic [4:0] count);
      word_type w;
      w.lo = {$urandom, $urandom};
      w.hi = {$urandom, $urandom};
      w.count = count;
      w.first = first;
      w.last = last;
      case ($urandom_range(0, 9))
         0: w.seed = 32'h0;
         1: w.seed = 32'hFFFFFFFF;
         default: w.seed = $urandom;
      endcase
      w.known = 1'b0;
      w.crc = 32'h0;
      return w;
   endfunction

   initial begin
      int n_full;
      int made;
      dir_tab = '{
         // lo, hi, count, first, last, seed, known, crc
         '{64'h0, 64'h0, 5'd0, 1'b0, 1'b1, 32'h0, 1'b1, 32'hFFFFFFFF},
         '{64'h3837363534333231, 64'h39, 5'd9, 1'b1, 1'b1, 32'h0, 1'b1, 32'hCBF43926},
         '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 32'h12345678, 1'b1, 32'h12345678},
         '{'1, '1, 5'd0, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
         '{'1, '1, 5'd0, 1'b1, 1'b1, 32'h0, 1'b1, 32'h0},
         '{'1, '1, 5'd16, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
         '{'1, '1, 5'd3, 1'b1, 1'b0, 32'hFFFFFFFF, 1'b0, 32'h0},
         '{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
         '{64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 5'd17, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0},
         '{64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd31, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
         '{64'h1, 64'h8000000000000000, 5'd16, 1'b1, 1'b0, 32'hDEADBEEF, 1'b0, 32'h0},
         '{'1, '1, 5'd31, 1'b0, 1'b1, '1, 1'b0, 32'h0},
         '{64'h80, 64'h0, 5'd1, 1'b1, 1'b1, 32'h0, 1'b0, 32'h0},
         '{64'hFEDCBA9876543210, 64'h00FF00FF00FF00FF, 5'd15, 1'b1, 1'b1, 32'h55AA55AA,
           1'b0, 32'h0},
         '{64'h0, 64'h0, 5'd16, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0, 32'h0},
         '{64'hCAFEF00D12345678, 64'h0, 5'd16, 1'b1, 1'b0, 32'h0, 1'b0, 32'h0},
         '{64'h0, 64'hFFFFFFFFFFFFFFFF, 5'd16, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0},
         '{64'h1111111111111111, 64'h2222222222222222, 5'd16, 1'b1, 1'b0, 32'h89ABCDEF,
           1'b0, 32'h0},
         '{64'h7766554433221100, 64'hFFEEDDCCBBAA9988, 5'd8, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0},
         '{'1, '1, 5'd16, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0}
      };
      foreach (dir_tab[i]) feed_q.push_back(dir_tab[i]);

      made = 0;
      while (made < RANDOM_WORDS) begin
         if ($urandom_range(0, 99) < 80) begin
            // well-formed message with random content
            n_full = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            for (int k = 0; k < n_full; k++) begin
               feed_q.push_back(rand_word(k == 0, 1'b0,
                  ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'd16));
            end
            feed_q.push_back(rand_word(n_full == 0, 1'b1,
               ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16))));
            made += n_full + 1;
         end else begin
            feed_q.push_back(rand_word($urandom_range(0, 1), $urandom_range(0, 1),
                                       5'($urandom_range(0, 31))));
            made++;
         end
      end
      total_words = feed_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (feed_q.size() > 0 || req_valid || crc_q.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("crc32_clmul_fold_core_test: clean");
      end else begin
         $display("crc32_clmul_fold_core_test: errors");
      end
      $finish;
   end

   always @(posedge clock) begin
      word_type    w;
      bit          has_crc;
      bit          taken;
      bit          moved;
      logic [31:0] crc;
      logic [31:0] want;
      int          send_idle;
      int          recv_idle;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (words_taken < total_words / 3) begin
            send_idle = 11;
            recv_idle = 58;
         end else if (words_taken < 2 * total_words / 3) begin
            send_idle = 58;
            recv_idle = 11;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end

         taken = req_valid && !req_stall;
         moved = taken;
         if (taken) begin
            w = feed_q.pop_front();
            predict_word(w, has_crc, crc);
            if (has_crc) crc_q.push_back(w.known ? w.crc : crc);
            words_taken++;
         end

         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (crc_q.size() == 0) begin
               $display("%0t crc with none expected: expected none, got %08h",
                        $time, rsp_crc_value);
               errors++;
            end else begin
               want = crc_q.pop_front();
               if (rsp_crc_value !== want) begin
                  $display("%0t crc_value mismatch: expected %08h, got %08h",
                           $time, want, rsp_crc_value);
                  errors++;
               end
            end
         end

         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("crc32_clmul_fold_core_test: errors");
            $finish;
         end

         if (!req_valid || taken) begin
            if (feed_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data_low <= feed_q[0].lo;
               req_data_high <= feed_q[0].hi;
               req_byte_count <= feed_q[0].count;
               req_first <= feed_q[0].first;
               req_last <= feed_q[0].last;
               req_seed <= feed_q[0].seed;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/crcf_pkg.sv
design/crcf_front.sv
design/crcf_queue.sv
design/crcf_back.sv
design/crc32_clmul_fold_core.sv
tb/sv/crc32_clmul_fold_core_test.sv
